>>> hw/rtl/mfrf_pkg.sv
// Package with shared constants, codes and types of the mesh flood relay filter.
`timescale 1ns / 1ps
package mfrf_pkg;

	// Default storage sizes.
	localparam int CACHE_DEPTH_DEF   = 16;
	localparam int HISTORY_DEPTH_DEF = 1024;
	localparam int SOURCE_SLOTS_DEF  = 64;

	// Configuration register reset values.
	localparam logic [4:0]  CACHE_SIZE_RST   = 5'd16;
	localparam logic        RELAY_ENABLE_RST = 1'b1;
	localparam logic [15:0] OWN_NODE_ID_RST  = 16'd0;
	localparam logic [7:0]  INITIAL_TTL_RST  = 8'd127;

	// Configuration port widths.
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CACHE_SIZE   = 2'd0,
		REG_RELAY_ENABLE = 2'd1,
		REG_OWN_NODE_ID  = 2'd2,
		REG_INITIAL_TTL  = 2'd3
	} cfg_reg_t;

	// Input command codes.
	typedef enum logic {
		CMD_RECEIVE   = 1'b0,
		CMD_ORIGINATE = 1'b1
	} cmd_t;

	// Result action codes.
	typedef enum logic [1:0] {
		ACT_NONE  = 2'd0,
		ACT_OWN   = 2'd1,
		ACT_RELAY = 2'd2
	} action_t;

endpackage

>>> hw/rtl/mfrf_if.sv
// Channel interfaces of the mesh flood relay filter: request, response and configuration.
`timescale 1ns / 1ps
interface mfrf_req_if import mfrf_pkg::*; ();
	logic               valid;
	logic               ready;
	logic               cmd;
	logic signed [31:0] msg_uid;
	logic [7:0]         msg_ttl;
	logic [15:0]        msg_src;
	modport source (output valid, cmd, msg_uid, msg_ttl, msg_src, input ready);
	modport sink (input valid, cmd, msg_uid, msg_ttl, msg_src, output ready);
endinterface

interface mfrf_rsp_if import mfrf_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [1:0]         action;
	logic signed [31:0] out_uid;
	logic [7:0]         out_ttl;
	logic [15:0]        out_src;
	logic               is_fresh;
	logic [31:0]        source_count;
	logic [31:0]        received_total;
	logic [31:0]        duplicate_total;
	logic [31:0]        miss_total;
	logic               table_full;
	modport source (output valid, action, out_uid, out_ttl, out_src, is_fresh, source_count,
		received_total, duplicate_total, miss_total, table_full, input ready);
	modport sink (input valid, action, out_uid, out_ttl, out_src, is_fresh, source_count,
		received_total, duplicate_total, miss_total, table_full, output ready);
endinterface

interface mfrf_cfg_if import mfrf_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

>>> hw/rtl/mesh_flood_relay_filter.sv
// Top level of the mesh flood relay filter: sequencer, shared compare unit and memories.
// An originate goes straight to the result; a receive walks the cache, then the history
// memory unless the cache hit, then the source table, one entry per cycle through the single
// shared compare unit, and then updates the source table.
// Throughput: one item at a time; a new item is taken once the previous result is out.
// Reset: arst_n clears control state, fills and counters and loads register defaults;
// memory contents are left as they are and never read before being written.
`timescale 1ns / 1ps
module mesh_flood_relay_filter import mfrf_pkg::*; #(
	parameter int CACHE_DEPTH   = CACHE_DEPTH_DEF,
	parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF,
	parameter int SOURCE_SLOTS  = SOURCE_SLOTS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	mfrf_req_if.sink   req,
	mfrf_rsp_if.source rsp,
	mfrf_cfg_if.sink   cfg
);

	localparam int CIDX_W  = (CACHE_DEPTH > 1) ? $clog2(CACHE_DEPTH) : 1;
	localparam int HIDX_W  = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
	localparam int SIDX_W  = (SOURCE_SLOTS > 1) ? $clog2(SOURCE_SLOTS) : 1;
	localparam int CFILL_W = $clog2(CACHE_DEPTH + 1);
	localparam int HFILL_W = $clog2(HISTORY_DEPTH + 1);
	localparam int SFILL_W = $clog2(SOURCE_SLOTS + 1);
	localparam int SCAN_W0 = (CFILL_W > HFILL_W) ? CFILL_W : HFILL_W;
	localparam int SCAN_W  = (SCAN_W0 > SFILL_W) ? SCAN_W0 : SFILL_W;

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_CSCAN = 6'b000010,
		S_HSCAN = 6'b000100,
		S_SSCAN = 6'b001000,
		S_UPD   = 6'b010000,
		S_DONE  = 6'b100000
	} state_t;

	state_t state_q;

	// Configuration registers.
	logic [4:0]  cache_size_q;
	logic        relay_enable_q;
	logic [15:0] own_node_id_q;
	logic [7:0]  initial_ttl_q;

	// Latched item.
	logic        cmd_q;
	logic [31:0] uid_q;
	logic [7:0]  ttl_q;
	logic [15:0] src_q;

	// Ring and table bookkeeping.
	logic [CFILL_W-1:0] cache_fill_q;
	logic [CIDX_W-1:0]  cache_head_q;
	logic [HFILL_W-1:0] hist_fill_q;
	logic [HIDX_W-1:0]  hist_head_q;
	logic [SFILL_W-1:0] src_used_q;
	logic [31:0]        fresh_cnt_q;
	logic [31:0]        dup_cnt_q;
	logic [31:0]        miss_cnt_q;

	// Scan state and per-item flags.
	logic [SCAN_W-1:0] idx_q;
	logic [SCAN_W-1:0] ridx_q;
	logic              pend_q;
	logic              cache_hit_q;
	logic              fresh_q;
	logic              slot_found_q;
	logic [SIDX_W-1:0] slot_q;
	logic [31:0]       cnt_q;
	logic              full_hit_q;

	// Memories and their registered read data.
	logic [31:0] cache_mem [CACHE_DEPTH];
	logic [31:0] hist_mem  [HISTORY_DEPTH];
	logic [15:0] saddr_mem [SOURCE_SLOTS];
	logic [31:0] scnt_mem  [SOURCE_SLOTS];
	logic [31:0] cache_rd_q;
	logic [31:0] hist_rd_q;
	logic [15:0] saddr_rd_q;
	logic [31:0] scnt_rd_q;

	logic [CFILL_W-1:0] cap;
	logic [SCAN_W-1:0]  limit;
	logic [31:0]        cmp_a;
	logic [31:0]        cmp_b;
	logic               match;
	logic               scan_end;
	logic               cache_we;
	logic [CIDX_W-1:0]  cache_waddr;
	logic               hist_we;
	logic               src_we;
	logic               saddr_we;
	logic [SIDX_W-1:0]  src_waddr;
	logic [31:0]        scnt_wdata;
	logic               req_fire;
	logic               rsp_load;

	// Effective cache capacity from the size register.
	always_comb begin
		if (cache_size_q == 5'd0) begin
			cap = CFILL_W'(1);
		end else if (32'(cache_size_q) > CACHE_DEPTH) begin
			cap = CFILL_W'(CACHE_DEPTH);
		end else begin
			cap = CFILL_W'(32'(cache_size_q));
		end
	end

	// Shared compare unit and scan limit, selected by the scan phase.
	always_comb begin
		case (state_q)
			S_HSCAN: begin
				limit = SCAN_W'(hist_fill_q);
				cmp_a = hist_rd_q;
				cmp_b = uid_q;
			end
			S_SSCAN: begin
				limit = SCAN_W'(src_used_q);
				cmp_a = {16'd0, saddr_rd_q};
				cmp_b = {16'd0, src_q};
			end
			default: begin
				limit = SCAN_W'(cache_fill_q);
				cmp_a = cache_rd_q;
				cmp_b = uid_q;
			end
		endcase
	end

	assign match    = pend_q && (cmp_a == cmp_b);
	assign scan_end = (idx_q >= limit) && !pend_q;
	assign req_fire = req.valid && req.ready;
	assign req.ready = (state_q == S_IDLE);
	assign cfg.ready = 1'b1;
	assign rsp_load = (state_q == S_DONE) && (!rsp.valid || rsp.ready);

	// Cache push on originate, or on a receive that missed the cache.
	assign cache_we = (req_fire && (req.cmd == CMD_ORIGINATE)) ||
		((state_q == S_CSCAN) && !match && scan_end);
	assign cache_waddr = (cache_fill_q < cap) ? CIDX_W'(cache_fill_q) : cache_head_q;
	assign hist_we = (state_q == S_HSCAN) && !match && scan_end;

	// Source table write: bump a found entry or append a new source.
	always_comb begin
		src_we     = 1'b0;
		saddr_we   = 1'b0;
		src_waddr  = slot_q;
		scnt_wdata = cnt_q + 32'd1;
		if ((state_q == S_UPD) && fresh_q) begin
			if (slot_found_q) begin
				src_we = 1'b1;
			end else if (32'(src_used_q) < SOURCE_SLOTS) begin
				src_we     = 1'b1;
				saddr_we   = 1'b1;
				src_waddr  = SIDX_W'(src_used_q);
				scnt_wdata = 32'd1;
			end
		end
	end

	// Cache memory.
	always_ff @(posedge clk) begin
		if (cache_we) begin
			cache_mem[cache_waddr] <= (state_q == S_IDLE) ? req.msg_uid : uid_q;
		end
		cache_rd_q <= cache_mem[idx_q[CIDX_W-1:0]];
	end

	// History memory.
	always_ff @(posedge clk) begin
		if (hist_we) begin
			hist_mem[(hist_fill_q < HFILL_W'(HISTORY_DEPTH)) ?
				HIDX_W'(hist_fill_q) : hist_head_q] <= uid_q;
		end
		hist_rd_q <= hist_mem[idx_q[HIDX_W-1:0]];
	end

	// Source address and count memories.
	always_ff @(posedge clk) begin
		if (saddr_we) begin
			saddr_mem[src_waddr] <= src_q;
		end
		if (src_we) begin
			scnt_mem[src_waddr] <= scnt_wdata;
		end
		saddr_rd_q <= saddr_mem[idx_q[SIDX_W-1:0]];
		scnt_rd_q  <= scnt_mem[idx_q[SIDX_W-1:0]];
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cache_size_q   <= CACHE_SIZE_RST;
			relay_enable_q <= RELAY_ENABLE_RST;
			own_node_id_q  <= OWN_NODE_ID_RST;
			initial_ttl_q  <= INITIAL_TTL_RST;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg_reg_t'(cfg.index))
				REG_CACHE_SIZE:   cache_size_q   <= cfg.data[4:0];
				REG_RELAY_ENABLE: relay_enable_q <= cfg.data[0];
				REG_OWN_NODE_ID:  own_node_id_q  <= cfg.data;
				REG_INITIAL_TTL:  initial_ttl_q  <= cfg.data[7:0];
				default: ;
			endcase
		end
	end

	// Sequencer, bookkeeping and counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			cache_fill_q <= '0;
			cache_head_q <= '0;
			hist_fill_q  <= '0;
			hist_head_q  <= '0;
			src_used_q   <= '0;
			fresh_cnt_q  <= '0;
			dup_cnt_q    <= '0;
			miss_cnt_q   <= '0;
			idx_q        <= '0;
			ridx_q       <= '0;
			pend_q       <= 1'b0;
			cmd_q        <= 1'b0;
			uid_q        <= '0;
			ttl_q        <= '0;
			src_q        <= '0;
			cache_hit_q  <= 1'b0;
			fresh_q      <= 1'b0;
			slot_found_q <= 1'b0;
			slot_q       <= '0;
			cnt_q        <= '0;
		end else begin
			// Cache ring update, and emptying on a size write.
			if (cfg.valid && cfg.ready && (cfg_reg_t'(cfg.index) == REG_CACHE_SIZE)) begin
				cache_fill_q <= '0;
				cache_head_q <= '0;
			end else if (cache_we) begin
				if (cache_fill_q < cap) begin
					cache_fill_q <= cache_fill_q + CFILL_W'(1);
				end else if (CFILL_W'(cache_head_q) + CFILL_W'(1) == cap) begin
					cache_head_q <= '0;
				end else begin
					cache_head_q <= cache_head_q + CIDX_W'(1);
				end
			end

			// History ring update.
			if (hist_we) begin
				if (hist_fill_q < HFILL_W'(HISTORY_DEPTH)) begin
					hist_fill_q <= hist_fill_q + HFILL_W'(1);
				end else if (32'(hist_head_q) + 1 == HISTORY_DEPTH) begin
					hist_head_q <= '0;
				end else begin
					hist_head_q <= hist_head_q + HIDX_W'(1);
				end
			end

			// Scan pointer: one read issued per cycle while the scan goes on.
			if ((state_q == S_CSCAN || state_q == S_HSCAN || state_q == S_SSCAN) &&
				!match && !scan_end) begin
				pend_q <= (idx_q < limit);
				ridx_q <= idx_q;
				if (idx_q < limit) begin
					idx_q <= idx_q + SCAN_W'(1);
				end
			end

			case (state_q)
				S_IDLE: begin
					if (req_fire) begin
						cmd_q        <= req.cmd;
						uid_q        <= req.msg_uid;
						ttl_q        <= req.msg_ttl;
						src_q        <= req.msg_src;
						cache_hit_q  <= 1'b0;
						fresh_q      <= 1'b0;
						slot_found_q <= 1'b0;
						idx_q        <= '0;
						pend_q       <= 1'b0;
						state_q      <= (req.cmd == CMD_ORIGINATE) ? S_DONE : S_CSCAN;
					end
				end
				S_CSCAN: begin
					if (match) begin
						cache_hit_q <= 1'b1;
						dup_cnt_q   <= dup_cnt_q + 32'd1;
						idx_q       <= '0;
						pend_q      <= 1'b0;
						state_q     <= S_SSCAN;
					end else if (scan_end) begin
						idx_q   <= '0;
						pend_q  <= 1'b0;
						state_q <= S_HSCAN;
					end
				end
				S_HSCAN: begin
					if (match) begin
						dup_cnt_q  <= dup_cnt_q + 32'd1;
						miss_cnt_q <= miss_cnt_q + 32'd1;
						idx_q      <= '0;
						pend_q     <= 1'b0;
						state_q    <= S_SSCAN;
					end else if (scan_end) begin
						fresh_q     <= 1'b1;
						fresh_cnt_q <= fresh_cnt_q + 32'd1;
						idx_q       <= '0;
						pend_q      <= 1'b0;
						state_q     <= S_SSCAN;
					end
				end
				S_SSCAN: begin
					if (match) begin
						slot_found_q <= 1'b1;
						slot_q       <= SIDX_W'(ridx_q);
						cnt_q        <= scnt_rd_q;
						state_q      <= S_UPD;
					end else if (scan_end) begin
						state_q <= S_UPD;
					end
				end
				S_UPD: begin
					if (fresh_q && !slot_found_q && (32'(src_used_q) < SOURCE_SLOTS)) begin
						src_used_q <= src_used_q + SFILL_W'(1);
					end
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (rsp_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// A fresh unknown source was logged unless the table was already full before it.
	always_ff @(posedge clk) begin
		if (state_q == S_UPD) begin
			full_hit_q <= fresh_q && !slot_found_q && (32'(src_used_q) >= SOURCE_SLOTS);
		end
	end

	// Output register: the result waits here until the sink takes the beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp.valid <= 1'b0;
		end else if (rsp_load) begin
			rsp.valid <= 1'b1;
		end else if (rsp.ready) begin
			rsp.valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_load) begin
			rsp.received_total  <= fresh_cnt_q;
			rsp.duplicate_total <= dup_cnt_q;
			rsp.miss_total      <= miss_cnt_q;
			if (cmd_q == CMD_ORIGINATE) begin
				rsp.action       <= ACT_OWN;
				rsp.out_uid      <= uid_q;
				rsp.out_ttl      <= initial_ttl_q;
				rsp.out_src      <= own_node_id_q;
				rsp.is_fresh     <= 1'b0;
				rsp.source_count <= '0;
				rsp.table_full   <= 1'b0;
			end else begin
				if (!cache_hit_q && (ttl_q != 8'd0) && relay_enable_q) begin
					rsp.action  <= ACT_RELAY;
					rsp.out_uid <= uid_q;
					rsp.out_ttl <= ttl_q - 8'd1;
					rsp.out_src <= src_q;
				end else begin
					rsp.action  <= ACT_NONE;
					rsp.out_uid <= '0;
					rsp.out_ttl <= '0;
					rsp.out_src <= '0;
				end
				rsp.is_fresh <= fresh_q;
				// The new source count was settled in the table update step.
				if (slot_found_q) begin
					rsp.source_count <= fresh_q ? cnt_q + 32'd1 : cnt_q;
					rsp.table_full   <= 1'b0;
				end else if (fresh_q && !full_hit_q) begin
					rsp.source_count <= 32'd1;
					rsp.table_full   <= 1'b0;
				end else begin
					rsp.source_count <= '0;
					rsp.table_full   <= fresh_q;
				end
			end
		end
	end

	// Bookkeeping stays within the capacities.
	a_cache_fill: assert property (@(posedge clk) disable iff (!arst_n)
		cache_fill_q <= cap)
		else $error("cache fill above capacity");
	a_cache_head: assert property (@(posedge clk) disable iff (!arst_n)
		(cache_head_q != '0) |-> (cache_fill_q == cap))
		else $error("cache head moved before the cache filled");
	a_hist_fill: assert property (@(posedge clk) disable iff (!arst_n)
		32'(hist_fill_q) <= HISTORY_DEPTH)
		else $error("history fill above depth");
	a_src_used: assert property (@(posedge clk) disable iff (!arst_n)
		32'(src_used_q) <= SOURCE_SLOTS)
		else $error("source table use above slot count");

endmodule

>>> verif/mfrf_sb.sv
// Scoreboard of the mesh flood relay filter: relay decision predictor and expected-result store.
`timescale 1ns / 1ps
import mfrf_pkg::*;

class mfrf_relay_sb;

	typedef struct packed {
		logic [1:0]  action;
		logic [31:0] out_uid;
		logic [7:0]  out_ttl;
		logic [15:0] out_src;
		logic        is_fresh;
		logic [31:0] source_count;
		logic [31:0] received_total;
		logic [31:0] duplicate_total;
		logic [31:0] miss_total;
		logic        table_full;
	} verdict_t;

	// Register copies.
	logic [4:0]  cache_size;
	logic        relay_on;
	logic [15:0] node_id;
	logic [7:0]  orig_ttl;

	// State copies.
	logic [31:0] cache_q[$];
	logic [31:0] hist_q[$];
	logic [15:0] src_addr[$];
	logic [31:0] src_cnt[$];
	logic [31:0] n_fresh, n_dup, n_miss;

	verdict_t pending_verdicts[$];
	int errors;

	function new();
		cache_size = CACHE_SIZE_RST;
		relay_on   = RELAY_ENABLE_RST;
		node_id    = OWN_NODE_ID_RST;
		orig_ttl   = INITIAL_TTL_RST;
		n_fresh = 0;
		n_dup = 0;
		n_miss = 0;
		errors = 0;
	endfunction

	function void write_reg(cfg_reg_t idx, logic [15:0] val);
		case (idx)
			REG_CACHE_SIZE: begin
				cache_size = val[4:0];
				cache_q.delete();
			end
			REG_RELAY_ENABLE: relay_on = val[0];
			REG_OWN_NODE_ID:  node_id = val;
			REG_INITIAL_TTL:  orig_ttl = val[7:0];
			default: ;
		endcase
	endfunction

	// FIFO ring modeled as a queue capped at its capacity.
	function void push_cache(logic [31:0] id);
		int cap;
		cap = cache_size < 1 ? 1 : (cache_size > CACHE_DEPTH_DEF ? CACHE_DEPTH_DEF : cache_size);
		cache_q = {cache_q, id};
		if (cache_q.size() > cap) void'(cache_q.pop_front());
	endfunction

	function int find_src(logic [15:0] s);
		foreach (src_addr[i]) if (src_addr[i] == s) return i;
		return -1;
	endfunction

	// Note an accepted input beat and queue its expected result.
	function void note_input(cmd_t cmd, logic [31:0] uid, logic [7:0] ttl, logic [15:0] s);
		verdict_t v;
		int slot;
		bit in_cache, in_hist;
		v = '0;
		if (cmd == CMD_ORIGINATE) begin
			push_cache(uid);
			v.action = ACT_OWN;
			v.out_uid = uid;
			v.out_ttl = orig_ttl;
			v.out_src = node_id;
		end else begin
			in_cache = 0;
			foreach (cache_q[i]) if (cache_q[i] == uid) in_cache = 1;
			if (in_cache) begin
				n_dup++;
			end else begin
				push_cache(uid);
				in_hist = 0;
				foreach (hist_q[i]) if (hist_q[i] == uid) in_hist = 1;
				if (!in_hist) begin
					v.is_fresh = 1'b1;
					n_fresh++;
					hist_q = {hist_q, uid};
					if (hist_q.size() > HISTORY_DEPTH_DEF) void'(hist_q.pop_front());
					slot = find_src(s);
					if (slot >= 0) src_cnt[slot]++;
					else if (src_addr.size() < SOURCE_SLOTS_DEF) begin
						src_addr = {src_addr, s};
						src_cnt = {src_cnt, 32'd1};
					end else v.table_full = 1'b1;
				end else begin
					n_dup++;
					n_miss++;
				end
				if (ttl > 0 && relay_on) begin
					v.action = ACT_RELAY;
					v.out_uid = uid;
					v.out_ttl = ttl - 8'd1;
					v.out_src = s;
				end
			end
			slot = find_src(s);
			if (slot >= 0) v.source_count = src_cnt[slot];
		end
		v.received_total = n_fresh;
		v.duplicate_total = n_dup;
		v.miss_total = n_miss;
		pending_verdicts = {pending_verdicts, v};
	endfunction

	function void cmp(string name, logic [31:0] e, logic [31:0] a);
		if (e !== a) begin
			$error("%s mismatch: expected %0h, got %0h", name, e, a);
			errors++;
		end
	endfunction

	// Check one accepted result beat against the oldest expectation.
	function void check_result(verdict_t got);
		verdict_t e;
		if (pending_verdicts.size() == 0) begin
			$error("unexpected result beat");
			errors++;
			return;
		end
		e = pending_verdicts.pop_front();
		cmp("action", e.action, got.action);
		cmp("out_uid", e.out_uid, got.out_uid);
		cmp("out_ttl", e.out_ttl, got.out_ttl);
		cmp("out_src", e.out_src, got.out_src);
		cmp("is_fresh", e.is_fresh, got.is_fresh);
		cmp("source_count", e.source_count, got.source_count);
		cmp("received_total", e.received_total, got.received_total);
		cmp("duplicate_total", e.duplicate_total, got.duplicate_total);
		cmp("miss_total", e.miss_total, got.miss_total);
		cmp("table_full", e.table_full, got.table_full);
	endfunction
endclass

>>> verif/testbench.sv
// Top of the mesh flood relay filter testbench: stimulus, response monitor and run control.
`timescale 1ns / 1ps
module testbench;
	import mfrf_pkg::*;

	logic clk;
	logic arst_n;
	mfrf_req_if req ();
	mfrf_rsp_if rsp ();
	mfrf_cfg_if cfg ();

	mesh_flood_relay_filter DUT (.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp), .cfg(cfg));

	mfrf_relay_sb relay_sb = new();
	longint cycles = 0;
	logic [31:0] recent_uids[$];
	int stall_phase = 0;

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	// Cycle limit: a run that overruns its budget stops with a failure.
	always @(posedge clk) begin
		cycles++;
		if (cycles > 3000000) begin
			$display("FAIL");
			$finish;
		end
	end

	// Response monitor samples on the rising edge.
	always @(posedge clk) begin
		if (arst_n && rsp.valid && rsp.ready)
			relay_sb.check_result({rsp.action, rsp.out_uid, rsp.out_ttl, rsp.out_src,
				rsp.is_fresh, rsp.source_count, rsp.received_total, rsp.duplicate_total,
				rsp.miss_total, rsp.table_full});
	end

	// Receiver stalls on its own pattern, with quiet stretches.
	always @(negedge clk) begin
		stall_phase <= (stall_phase + 1) % 400;
		if (stall_phase < 150) rsp.ready <= 1'b1;
		else rsp.ready <= ($urandom_range(0, 2) != 0);
	end

	task automatic send_beat(cmd_t c, logic [31:0] uid, logic [7:0] ttl, logic [15:0] s);
		req.valid <= 1'b1;
		req.cmd <= c;
		req.msg_uid <= uid;
		req.msg_ttl <= ttl;
		req.msg_src <= s;
		@(posedge clk);
		while (!req.ready) @(posedge clk);
		relay_sb.note_input(c, uid, ttl, s);
		if (recent_uids.size() > 40) void'(recent_uids.pop_front());
		recent_uids = {recent_uids, uid};
		@(negedge clk);
	endtask

	task automatic idle_gap(int n);
		req.valid <= 1'b0;
		repeat (n) @(negedge clk);
	endtask

	task automatic write_cfg(cfg_reg_t idx, logic [15:0] val);
		// Registers change only when the block is idle.
		req.valid <= 1'b0;
		while (relay_sb.pending_verdicts.size() != 0) @(negedge clk);
		repeat (20) @(negedge clk);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= val;
		@(posedge clk);
		while (!cfg.ready) @(posedge clk);
		relay_sb.write_reg(idx, val);
		@(negedge clk);
		cfg.valid <= 1'b0;
	endtask

	// Random beat: mostly receives, with ids sometimes reused from recent beats, from a moderate set of sources.
	task automatic random_beat();
		logic [31:0] uid;
		logic [15:0] s;
		cmd_t c;
		c = ($urandom_range(0, 5) == 0) ? CMD_ORIGINATE : CMD_RECEIVE;
		if (recent_uids.size() > 0 && $urandom_range(0, 2) == 0)
			uid = recent_uids[$urandom_range(0, recent_uids.size() - 1)];
		else uid = $urandom();
		s = ($urandom_range(0, 3) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 80));
		send_beat(c, uid, 8'($urandom()), s);
	endtask

	initial begin
		int left, burst;
		arst_n = 1'b0;
		req.valid = 1'b0;
		req.cmd = CMD_RECEIVE;
		req.msg_uid = '0;
		req.msg_ttl = '0;
		req.msg_src = '0;
		cfg.valid = 1'b0;
		cfg.index = REG_CACHE_SIZE;
		cfg.data = '0;
		rsp.ready = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: field extremes, both commands, cache hit and history miss.
		send_beat(CMD_RECEIVE, 32'h8000_0000, 8'd255, 16'hFFFF);
		send_beat(CMD_RECEIVE, 32'h8000_0000, 8'd255, 16'hFFFF);
		send_beat(CMD_RECEIVE, 32'h7FFF_FFFF, 8'd0, 16'h0000);
		send_beat(CMD_RECEIVE, 32'hFFFF_FFFF, 8'd1, 16'h0000);
		send_beat(CMD_ORIGINATE, 32'h0000_0000, 8'd5, 16'h1234);
		send_beat(CMD_RECEIVE, 32'h0000_0000, 8'd9, 16'h0001);
		write_cfg(REG_CACHE_SIZE, 16'd1);
		write_cfg(REG_OWN_NODE_ID, 16'hFFFF);
		write_cfg(REG_INITIAL_TTL, 16'd255);
		send_beat(CMD_RECEIVE, 32'h1111_0000, 8'd3, 16'h0002);
		send_beat(CMD_RECEIVE, 32'h2222_0000, 8'd3, 16'h0002);
		send_beat(CMD_RECEIVE, 32'h1111_0000, 8'd3, 16'h0002); // history catches
		send_beat(CMD_ORIGINATE, 32'h2222_0000, 8'd0, 16'h0000);
		send_beat(CMD_ORIGINATE, 32'h2222_0000, 8'd0, 16'h0000);
		write_cfg(REG_RELAY_ENABLE, 16'd0);
		write_cfg(REG_INITIAL_TTL, 16'd0);
		send_beat(CMD_RECEIVE, 32'h3333_0000, 8'd7, 16'h0003);
		send_beat(CMD_ORIGINATE, 32'h4444_0000, 8'd0, 16'h0003);
		write_cfg(REG_CACHE_SIZE, 16'd0);   // taken as one
		send_beat(CMD_RECEIVE, 32'h3333_0000, 8'd7, 16'h0003);
		write_cfg(REG_CACHE_SIZE, 16'd31);  // clamps to depth
		write_cfg(REG_RELAY_ENABLE, 16'd1);
		write_cfg(REG_OWN_NODE_ID, 16'd0);
		// Fill the source table so later new sources overflow it.
		for (int i = 0; i < 70; i++)
			send_beat(CMD_RECEIVE, 32'hA000_0000 + i, 8'($urandom()), 16'(1000 + i));

		// Random part in phases with varying settings.
		for (int ph = 0; ph < 4; ph++) begin
			left = 120;
			while (left > 0) begin
				burst = $urandom_range(1, 12);
				if (burst > left) burst = left;
				repeat (burst) random_beat();
				left -= burst;
				if ($urandom_range(0, 3) != 0) idle_gap($urandom_range(1, 30));
			end
			write_cfg(REG_CACHE_SIZE, 16'($urandom_range(1, 16)));
			write_cfg(REG_RELAY_ENABLE, 16'($urandom_range(0, 1)));
			write_cfg(REG_OWN_NODE_ID, 16'($urandom()));
			write_cfg(REG_INITIAL_TTL, 16'($urandom_range(0, 255)));
		end
		req.valid <= 1'b0;

		while (relay_sb.pending_verdicts.size() != 0) @(negedge clk);
		repeat (50) @(negedge clk);
		if (relay_sb.errors == 0 && relay_sb.pending_verdicts.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end
endmodule
